// File: design/tls_pkg.sv
package tls_pkg;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_SORT_MODE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHECK_ONLY = 1'd1;

	localparam logic [1:0] ACT_LOAD    = 2'd0;
	localparam logic [1:0] ACT_PROCESS = 2'd1;
	localparam logic [1:0] ACT_FETCH   = 2'd2;
	localparam logic [1:0] ACT_UNUSED  = 2'd3;

	localparam logic [1:0] MODE_KEEP    = 2'd0;
	localparam logic [1:0] MODE_BYTES   = 2'd1;
	localparam logic [1:0] MODE_NUMERIC = 2'd2;
	localparam logic [1:0] MODE_FOLD    = 2'd3;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_DROPPED = 2'd1;
	localparam logic [1:0] STAT_EMPTY   = 2'd2;

	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;
	localparam logic [7:0] CH_AT    = 8'd64;
	localparam logic [7:0] CH_LBRK  = 8'd91;
	localparam logic [7:0] CASE_GAP = 8'd32;

	localparam logic [31:0] KEY_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] MAG_CAP = 32'h8000_0000;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] in_byte;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_line;
		logic       last_of_file;
		logic       unsorted;
		logic [1:0] status;
	} out_t;

	typedef enum logic [4:0] {
		S_IDLE, S_PCLOSE, S_INIT, S_PICK, S_CHK, S_CHK_NEXT,
		S_FOLD_LINE, S_FOLD_ADR, S_FOLD_TST,
		S_KEY_LINE, S_KEY_ADR, S_KEY_EV,
		S_SORT_I, S_SORT_V, S_SORT_J, S_SORT_P, S_SORT_CMPD, S_SORT_PLACE,
		S_CMP_ADR, S_CMP_EV, S_PDONE,
		S_F_ORD, S_F_LEN, S_F_RD, S_F_OUT
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_PCLOSE, OP_INIT, OP_PICK, OP_CHK, OP_CHK_NEXT,
		OP_FOLD_LINE, OP_FOLD_TST,
		OP_KEY_LINE, OP_KEY_EV,
		OP_SORT_I, OP_SORT_V, OP_SORT_J, OP_SORT_P, OP_SORT_CMPD, OP_SORT_PLACE,
		OP_CMP_EV, OP_PDONE,
		OP_F_ORD, OP_F_LEN, OP_F_OUT
	} op_t;

	typedef struct packed {
		op_t  op;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic       i_lt_lc;
		logic       rl_lt_lc;
		logic       j_zero;
		logic       k_lt_len;
		logic       key_fin;
		logic       cmp_fin;
		logic       gt;
		logic [1:0] mode;
		logic       chk;
		logic       out_busy;
	} dp_status_t;

endpackage

// File: design/tls_ctrl.sv
module tls_ctrl import tls_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_action,
	input  dp_status_t st,
	output cmd_t       cmd,
	output logic       in_stall
);

	state_t state_q, state_d;
	logic   ret_sort_q;
	logic   accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ret_sort_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_SORT_P)
				ret_sort_q <= 1'b1;
			else if (state_q == S_CHK)
				ret_sort_q <= 1'b0;
		end
	end

	assign accept = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && in_action == ACT_PROCESS)
					state_d = S_PCLOSE;
				else if (accept && in_action == ACT_FETCH)
					state_d = S_F_ORD;
			end
			S_PCLOSE:     state_d = S_INIT;
			S_INIT:       state_d = st.i_lt_lc ? S_INIT : S_PICK;
			S_PICK: begin
				if (st.chk)
					state_d = S_CHK;
				else begin
					case (st.mode)
						MODE_KEEP:    state_d = S_PDONE;
						MODE_FOLD:    state_d = S_FOLD_LINE;
						MODE_NUMERIC: state_d = S_KEY_LINE;
						default:      state_d = S_SORT_I;
					endcase
				end
			end
			S_CHK:        state_d = st.i_lt_lc ? S_CMP_ADR : S_PDONE;
			S_CHK_NEXT:   state_d = S_CHK;
			S_FOLD_LINE:  state_d = st.i_lt_lc ? S_FOLD_ADR : S_SORT_I;
			S_FOLD_ADR:   state_d = S_FOLD_TST;
			S_FOLD_TST:   state_d = st.k_lt_len ? S_FOLD_ADR : S_FOLD_LINE;
			S_KEY_LINE:   state_d = st.i_lt_lc ? S_KEY_ADR : S_SORT_I;
			S_KEY_ADR:    state_d = S_KEY_EV;
			S_KEY_EV:     state_d = st.key_fin ? S_KEY_LINE : S_KEY_ADR;
			S_SORT_I:     state_d = st.i_lt_lc ? S_SORT_V : S_PDONE;
			S_SORT_V:     state_d = S_SORT_J;
			S_SORT_J:     state_d = st.j_zero ? S_SORT_PLACE : S_SORT_P;
			S_SORT_P:     state_d = S_CMP_ADR;
			S_SORT_CMPD:  state_d = st.gt ? S_SORT_J : S_SORT_PLACE;
			S_SORT_PLACE: state_d = S_SORT_I;
			S_CMP_ADR:    state_d = S_CMP_EV;
			S_CMP_EV: begin
				if (st.cmp_fin)
					state_d = ret_sort_q ? S_SORT_CMPD : S_CHK_NEXT;
				else
					state_d = S_CMP_ADR;
			end
			S_PDONE:      state_d = S_IDLE;
			S_F_ORD:      state_d = st.rl_lt_lc ? S_F_LEN : S_IDLE;
			S_F_LEN:      state_d = S_F_RD;
			S_F_RD:       state_d = S_F_OUT;
			S_F_OUT:      state_d = S_IDLE;
			default:      state_d = S_IDLE;
		endcase
	end

	always_comb begin
		// loads never produce a result, so they pass a waiting result
		in_stall = !(state_q == S_IDLE && (!st.out_busy || in_action == ACT_LOAD ||
			in_action == ACT_UNUSED));
		cmd.load = (state_q == S_IDLE) && in_valid && !in_stall && in_action == ACT_LOAD;
		case (state_q)
			S_PCLOSE:     cmd.op = OP_PCLOSE;
			S_INIT:       cmd.op = OP_INIT;
			S_PICK:       cmd.op = OP_PICK;
			S_CHK:        cmd.op = OP_CHK;
			S_CHK_NEXT:   cmd.op = OP_CHK_NEXT;
			S_FOLD_LINE:  cmd.op = OP_FOLD_LINE;
			S_FOLD_TST:   cmd.op = OP_FOLD_TST;
			S_KEY_LINE:   cmd.op = OP_KEY_LINE;
			S_KEY_EV:     cmd.op = OP_KEY_EV;
			S_SORT_I:     cmd.op = OP_SORT_I;
			S_SORT_V:     cmd.op = OP_SORT_V;
			S_SORT_J:     cmd.op = OP_SORT_J;
			S_SORT_P:     cmd.op = OP_SORT_P;
			S_SORT_CMPD:  cmd.op = OP_SORT_CMPD;
			S_SORT_PLACE: cmd.op = OP_SORT_PLACE;
			S_CMP_EV:     cmd.op = OP_CMP_EV;
			S_PDONE:      cmd.op = OP_PDONE;
			S_F_ORD:      cmd.op = OP_F_ORD;
			S_F_LEN:      cmd.op = OP_F_LEN;
			S_F_OUT:      cmd.op = OP_F_OUT;
			default:      cmd.op = OP_NONE;
		endcase
	end

endmodule

// File: design/tls_datapath.sv
module tls_datapath import tls_pkg::*; #(
	parameter int MAX_LINES  = 128,
	parameter int LINE_BYTES = 128
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	input  in_t                   in_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  out_stall,
	output dp_status_t            st,
	output logic                  out_valid,
	output out_t                  out_data
);

	localparam int LIW   = $clog2(MAX_LINES);
	localparam int LCW   = $clog2(MAX_LINES + 1);
	localparam int CW    = $clog2(LINE_BYTES);
	localparam int DEPTH = MAX_LINES * LINE_BYTES;
	localparam int TAW   = $clog2(DEPTH);

	logic [7:0]    text_mem [DEPTH];
	logic [CW-1:0] len_mem  [MAX_LINES];
	logic [LIW-1:0] ord_mem [MAX_LINES];
	logic [31:0]   key_mem  [MAX_LINES];

	logic [7:0]     txa_q, txb_q;
	logic [CW-1:0]  lna_q, lnb_q;
	logic [LIW-1:0] ord_q;
	logic [31:0]    kya_q, kyb_q;

	logic [LCW-1:0] lc_q, rl_q, i_q, j_q;
	logic [CW-1:0]  col_q, rc_q, k_q;
	logic [LIW-1:0] v_q, p_q, ra_q, rb_q;
	logic [1:0]     mode_q;
	logic           chk_q, drop_q, unsorted_q, gt_q, neg_q, dig_q;
	logic [31:0]    mag_q;
	logic           out_valid_q;
	out_t           out_q;

	logic [TAW-1:0] txa_addr, txb_addr, load_addr;
	logic           full, load_close, pclose;
	logic [CW:0]    col_inc, k1;
	logic [LCW:0]   rl1;
	logic [LCW-1:0] im1, jm1;
	logic [LIW-1:0] ord_raddr;
	logic [CW-1:0]  n_min;
	logic           numeric, k_lt_len, k_ge_n, cmp_gt, cmp_fin;
	logic           is_ws, is_sign, is_dig, key_fin, lol, lof;
	logic [7:0]     fold_byte;
	logic [35:0]    m36;
	logic [31:0]    mag_next, key_val;

	logic           tx_we, ln_we, or_we, ky_we;
	logic [TAW-1:0] tx_waddr;
	logic [7:0]     tx_wdata;
	logic [LIW-1:0] ln_waddr, or_waddr, or_wdata, ky_waddr;
	logic [CW-1:0]  ln_wdata;

	assign txa_addr  = TAW'(ra_q) * TAW'(LINE_BYTES) + TAW'(k_q);
	assign txb_addr  = TAW'(rb_q) * TAW'(LINE_BYTES) + TAW'(k_q);
	assign load_addr = TAW'(lc_q[LIW-1:0]) * TAW'(LINE_BYTES) + TAW'(col_q);

	assign full       = lc_q >= LCW'(MAX_LINES);
	assign col_inc    = {1'b0, col_q} + 1'b1;
	assign load_close = (in_data.in_byte == CH_NL) || (col_inc >= (CW+1)'(LINE_BYTES - 1));
	assign pclose     = (col_q != '0) && !full;
	assign im1        = i_q - 1'b1;
	assign jm1        = j_q - 1'b1;

	assign numeric  = (mode_q == MODE_NUMERIC) && !chk_q;
	assign k_lt_len = k_q < lna_q;
	assign n_min    = (lna_q < lnb_q) ? lna_q : lnb_q;
	assign k_ge_n   = k_q >= n_min;
	assign cmp_fin  = numeric || k_ge_n || (txa_q != txb_q);
	assign cmp_gt   = numeric ? ($signed(kya_q) > $signed(kyb_q)) :
		(k_ge_n ? (lna_q > lnb_q) : (txa_q > txb_q));

	assign fold_byte = (txa_q > CH_AT && txa_q < CH_LBRK) ? txa_q + CASE_GAP : txa_q;

	assign is_ws   = txa_q >= CH_TAB && txa_q <= CH_CR;
	assign is_sign = txa_q == CH_PLUS || txa_q == CH_MINUS;
	assign is_dig  = txa_q >= CH_ZERO && txa_q <= CH_NINE;
	assign m36     = ({4'd0, mag_q} << 3) + ({4'd0, mag_q} << 1) + 36'(txa_q - CH_ZERO);
	assign mag_next = (m36 > 36'(MAG_CAP)) ? MAG_CAP : m36[31:0];
	assign key_fin = !k_lt_len || (dig_q && !is_dig);
	assign key_val = neg_q ? (32'd0 - mag_q) : (mag_q[31] ? KEY_MAX : mag_q);

	assign k1  = {1'b0, k_q} + 1'b1;
	assign lol = k1 >= {1'b0, lna_q};
	assign rl1 = {1'b0, rl_q} + 1'b1;
	assign lof = rl1 >= {1'b0, lc_q};

	always_comb begin
		case (cmd.op)
			OP_SORT_I: ord_raddr = i_q[LIW-1:0];
			OP_SORT_J: ord_raddr = jm1[LIW-1:0];
			default:   ord_raddr = rl_q[LIW-1:0];
		endcase
	end

	always_comb begin
		tx_we    = 1'b0;
		tx_waddr = txa_addr;
		tx_wdata = fold_byte;
		if (cmd.load && !full) begin
			tx_we    = 1'b1;
			tx_waddr = load_addr;
			tx_wdata = in_data.in_byte;
		end else if (cmd.op == OP_FOLD_TST && k_lt_len) begin
			tx_we = 1'b1;
		end

		ln_we    = 1'b0;
		ln_waddr = lc_q[LIW-1:0];
		ln_wdata = col_q;
		or_we    = 1'b0;
		or_waddr = lc_q[LIW-1:0];
		or_wdata = lc_q[LIW-1:0];
		if (cmd.load && !full && load_close) begin
			ln_we    = 1'b1;
			ln_wdata = col_inc[CW-1:0];
			or_we    = 1'b1;
		end else begin
			case (cmd.op)
				OP_PCLOSE: begin
					ln_we = pclose;
					or_we = pclose;
				end
				OP_INIT: begin
					or_we    = i_q < lc_q;
					or_waddr = i_q[LIW-1:0];
					or_wdata = i_q[LIW-1:0];
				end
				OP_SORT_CMPD: begin
					or_we    = gt_q;
					or_waddr = j_q[LIW-1:0];
					or_wdata = p_q;
				end
				OP_SORT_PLACE: begin
					or_we    = 1'b1;
					or_waddr = j_q[LIW-1:0];
					or_wdata = v_q;
				end
				default: or_we = 1'b0;
			endcase
		end

		ky_we    = (cmd.op == OP_KEY_EV) && key_fin;
		ky_waddr = i_q[LIW-1:0];
	end

	always_ff @(posedge clk) begin
		if (tx_we)
			text_mem[tx_waddr] <= tx_wdata;
		if (ln_we)
			len_mem[ln_waddr] <= ln_wdata;
		if (or_we)
			ord_mem[or_waddr] <= or_wdata;
		if (ky_we)
			key_mem[ky_waddr] <= key_val;
		txa_q <= text_mem[txa_addr];
		txb_q <= text_mem[txb_addr];
		lna_q <= len_mem[ra_q];
		lnb_q <= len_mem[rb_q];
		ord_q <= ord_mem[ord_raddr];
		kya_q <= key_mem[ra_q];
		kyb_q <= key_mem[rb_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lc_q       <= '0;
			col_q      <= '0;
			rl_q       <= '0;
			rc_q       <= '0;
			drop_q     <= 1'b0;
			mode_q     <= MODE_BYTES;
			chk_q      <= 1'b0;
			unsorted_q <= 1'b0;
			gt_q       <= 1'b0;
			i_q        <= '0;
			j_q        <= '0;
			k_q        <= '0;
			v_q        <= '0;
			p_q        <= '0;
			ra_q       <= '0;
			rb_q       <= '0;
			neg_q      <= 1'b0;
			dig_q      <= 1'b0;
			mag_q      <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SORT_MODE:  mode_q <= cfg_data[1:0];
					CFG_CHECK_ONLY: chk_q  <= cfg_data[0];
					default:        ;
				endcase
			end
			if (cmd.load) begin
				if (full)
					drop_q <= 1'b1;
				else if (load_close) begin
					col_q <= '0;
					lc_q  <= lc_q + 1'b1;
				end else
					col_q <= col_inc[CW-1:0];
			end
			case (cmd.op)
				OP_PCLOSE: begin
					if (pclose)
						lc_q <= lc_q + 1'b1;
					col_q      <= '0;
					rl_q       <= '0;
					rc_q       <= '0;
					unsorted_q <= 1'b0;
					i_q        <= '0;
				end
				OP_INIT: begin
					if (i_q < lc_q)
						i_q <= i_q + 1'b1;
				end
				OP_PICK: i_q <= (chk_q || mode_q == MODE_BYTES) ? LCW'(1) : '0;
				OP_CHK: begin
					ra_q <= im1[LIW-1:0];
					rb_q <= i_q[LIW-1:0];
					k_q  <= '0;
				end
				OP_CHK_NEXT: begin
					if (gt_q)
						unsorted_q <= 1'b1;
					i_q <= i_q + 1'b1;
				end
				OP_FOLD_LINE: begin
					if (i_q < lc_q) begin
						ra_q <= i_q[LIW-1:0];
						k_q  <= '0;
					end else
						i_q <= LCW'(1);
				end
				OP_FOLD_TST: begin
					if (k_lt_len)
						k_q <= k_q + 1'b1;
					else
						i_q <= i_q + 1'b1;
				end
				OP_KEY_LINE: begin
					if (i_q < lc_q) begin
						ra_q  <= i_q[LIW-1:0];
						k_q   <= '0;
						neg_q <= 1'b0;
						dig_q <= 1'b0;
						mag_q <= '0;
					end else
						i_q <= LCW'(1);
				end
				OP_KEY_EV: begin
					if (key_fin)
						i_q <= i_q + 1'b1;
					else if (!dig_q) begin
						// skip leading white space, take one sign, then digits
						if (is_ws)
							k_q <= k_q + 1'b1;
						else if (is_sign) begin
							neg_q <= txa_q == CH_MINUS;
							k_q   <= k_q + 1'b1;
							dig_q <= 1'b1;
						end else
							dig_q <= 1'b1;
					end else begin
						mag_q <= mag_next;
						k_q   <= k_q + 1'b1;
					end
				end
				OP_SORT_V: begin
					v_q <= ord_q;
					j_q <= i_q;
				end
				OP_SORT_P: begin
					p_q  <= ord_q;
					ra_q <= ord_q;
					rb_q <= v_q;
					k_q  <= '0;
				end
				OP_SORT_CMPD: begin
					if (gt_q)
						j_q <= jm1;
				end
				OP_SORT_PLACE: i_q <= i_q + 1'b1;
				OP_CMP_EV: begin
					if (cmp_fin)
						gt_q <= cmp_gt;
					else
						k_q <= k_q + 1'b1;
				end
				OP_F_LEN: begin
					ra_q <= ord_q;
					k_q  <= rc_q;
				end
				OP_F_OUT: begin
					if (lol) begin
						rl_q <= rl_q + 1'b1;
						rc_q <= '0;
					end else
						rc_q <= k1[CW-1:0];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.op == OP_PDONE || cmd.op == OP_F_OUT ||
				(cmd.op == OP_F_ORD && !(rl_q < lc_q)))
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_PDONE: out_q <= '{out_byte: 8'd0, last_of_line: 1'b0, last_of_file: 1'b0,
				unsorted: unsorted_q, status: drop_q ? STAT_DROPPED : STAT_OK};
			OP_F_ORD: out_q <= '{out_byte: 8'd0, last_of_line: 1'b0, last_of_file: 1'b0,
				unsorted: 1'b0, status: STAT_EMPTY};
			OP_F_OUT: out_q <= '{out_byte: txa_q, last_of_line: lol, last_of_file: lol && lof,
				unsorted: 1'b0, status: drop_q ? STAT_DROPPED : STAT_OK};
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign st.i_lt_lc  = i_q < lc_q;
	assign st.rl_lt_lc = rl_q < lc_q;
	assign st.j_zero   = j_q == '0;
	assign st.k_lt_len = k_lt_len;
	assign st.key_fin  = key_fin;
	assign st.cmp_fin  = cmp_fin;
	assign st.gt       = gt_q;
	assign st.mode     = mode_q;
	assign st.chk      = chk_q;
	assign st.out_busy = out_valid_q;

endmodule

// File: design/text_line_sorter_unit.sv
// Line sorter: text is loaded one byte per request and split into lines at each
// newline or after LINE_BYTES-1 bytes; up to MAX_LINES lines are held, later bytes
// are dropped and flagged in status. A load request is taken even while a result
// waits on the output. A process request closes any partial line and then, by
// sort_mode and check_only, checks adjacent lines, keeps load order, sorts
// bytewise, sorts stably by a leading signed number, or folds A-Z to lower case in
// the stored text and sorts bytewise. Processing rebuilds the order table for the
// N lines, then case folding or key extraction steps through the stored bytes, and
// each line compare of an insertion sort looks at bytes one by one, as every step
// goes through the registered reads of the text store. A fetch request returns the
// next byte through the order, length and text reads, or status 2 when nothing is
// left. No clearing pass after reset.
module text_line_sorter_unit import tls_pkg::*; #(
	parameter int MAX_LINES  = 128,
	parameter int LINE_BYTES = 128
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_t                   in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_t                  out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t       cmd;
	dp_status_t st;

	tls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_action (in_data.action),
		.st        (st),
		.cmd       (cmd),
		.in_stall  (in_stall)
	);

	tls_datapath #(
		.MAX_LINES  (MAX_LINES),
		.LINE_BYTES (LINE_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_stall (out_stall),
		.st        (st),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

// File: design/tls_checker.sv
module tls_props import tls_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input in_t                   in_data,
	input logic                  out_valid,
	input logic                  out_stall,
	input out_t                  out_data,
	input logic                  cfg_we,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result dropped or changed under stall");

	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == STAT_EMPTY |->
			out_data.out_byte == 8'd0 && !out_data.last_of_line && !out_data.unsorted)
		else $error("empty fetch carries data");

	a_file_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.last_of_file |-> out_data.last_of_line)
		else $error("end of text not at end of line");

	a_check_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.unsorted |->
			out_data.out_byte == 8'd0 && !out_data.last_of_line && out_data.status != STAT_EMPTY)
		else $error("check result mixed with byte data");

endmodule

bind text_line_sorter_unit tls_props u_tls_checker (.*);
